/* rtl/hsip_pkg.sv */
// Shared types and codes for the slice header identity parser.
// No dependencies; imported by every module of the block.
package hsip_pkg;

   // Status codes of a result transaction
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_SHORT    = 3'd1;
   localparam logic [2:0] STATUS_HEADER   = 3'd2;
   localparam logic [2:0] STATUS_NO_BITS  = 3'd3;
   localparam logic [2:0] STATUS_GOLOMB   = 3'd4;
   localparam logic [2:0] STATUS_RANGE    = 3'd5;

   // IRAP type range that carries the no-output flag
   localparam logic [5:0] IRAP_FIRST_TYPE = 6'd16;
   localparam logic [5:0] IRAP_LAST_TYPE  = 6'd23;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] unit_kind;
      logic [2:0] temporal_level;
      logic       first_slice_flag;
      logic       no_output_prior_flag;
      logic [5:0] pps_id;
   } rsp_type;

endpackage

/* rtl/hsip_parser.sv */
// Per-byte parse step and parse state of the slice header identity parser.
// Depends on hsip_pkg. Result is combinational; the caller registers it.
module hsip_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  hsip_pkg::req_type item,
   output hsip_pkg::rsp_type result
);
   import hsip_pkg::*;

   typedef enum logic [2:0] {
      PH_FIRST  = 3'd0,
      PH_NOOUT  = 3'd1,
      PH_ZEROS  = 3'd2,
      PH_SUFFIX = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] flags;   // bit 1 first-slice, bit 0 no-output
      logic [5:0] lz;
      logic [5:0] sv;      // suffix bits, then the final id
      logic [5:0] sl;
      logic [2:0] err;
   } bit_state_type;

   typedef struct packed {
      logic [23:0]   lead;
      logic [2:0]    bc;
      logic [1:0]    pc;
      logic [7:0]    hf;
      logic [7:0]    hs;
      logic [1:0]    zr;
      bit_state_type bs;
   } pstate_type;

   localparam pstate_type ST_RESET = '0;

   function automatic bit_state_type take_bit(bit_state_type s, logic b, logic [5:0] t);
      bit_state_type n;
      logic [6:0]    mask;
      logic [6:0]    v;
      logic [5:0]    sv_n;
      logic [5:0]    sl_n;
      logic [5:0]    lz_n;
      n    = s;
      mask = 7'((7'd1 << s.lz[2:0]) - 7'd1);
      sv_n = {s.sv[4:0], b};
      sl_n = s.sl - 6'd1;
      lz_n = s.lz + 6'd1;
      v    = mask + {1'b0, sv_n};
      if (s.err == STATUS_OK) begin
         unique case (s.phase)
            PH_FIRST: begin
               n.flags[1] = b;
               n.phase = (t >= IRAP_FIRST_TYPE && t <= IRAP_LAST_TYPE) ? PH_NOOUT : PH_ZEROS;
            end
            PH_NOOUT: begin
               n.flags[0] = b;
               n.phase = PH_ZEROS;
            end
            PH_ZEROS: begin
               if (b) begin
                  n.sv = '0;
                  if (s.lz == '0) begin
                     n.phase = PH_DONE;
                  end else begin
                     n.sl = s.lz;
                     n.phase = PH_SUFFIX;
                  end
               end else begin
                  n.lz = lz_n;
                  if (lz_n > 6'd31) n.err = STATUS_GOLOMB;
               end
            end
            PH_SUFFIX: begin
               n.sv = sv_n;
               n.sl = sl_n;
               if (sl_n == '0) begin
                  // codes longer than six suffix bits always exceed the id range
                  if (s.lz > 6'd6 || v[6]) n.err = STATUS_RANGE;
                  n.sv = v[5:0];
                  n.phase = PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end
      return n;
   endfunction

   function automatic pstate_type check_header(pstate_type s);
      pstate_type n;
      n = s;
      if (s.hf[7] || s.hf[6] || {s.hf[0], s.hs[7:3]} != '0 || s.hs[2:0] != 3'd1)
         n.bs.err = STATUS_HEADER;
      return n;
   endfunction

   function automatic pstate_type take_payload(pstate_type s, logic [7:0] b);
      pstate_type n;
      n = s;
      if (s.pc != 2'd3) n.pc = s.pc + 2'd1;
      if (s.bs.err == STATUS_OK) begin
         if (s.zr == 2'd2 && b == 8'h03) begin
            // drop emulation-prevention byte
            n.zr = '0;
         end else begin
            for (int i = 7; i >= 0; i--) begin
               if (n.bs.err == STATUS_OK && n.bs.phase != PH_DONE)
                  n.bs = take_bit(n.bs, b[i], s.hf[6:1]);
            end
            if (b == '0) n.zr = (s.zr == 2'd2) ? 2'd2 : s.zr + 2'd1;
            else n.zr = '0;
         end
      end
      return n;
   endfunction

   pstate_type st_ff;
   pstate_type st_in;
   pstate_type nx;
   logic [2:0] idx;
   logic [2:0] prefix;
   logic [2:0] pos;
   logic [2:0] status;
   logic       pending;

   always_comb begin
      nx     = st_ff;
      idx    = st_ff.bc;
      prefix = '0;
      pos    = '0;
      if (st_ff.bc != 3'd7) nx.bc = st_ff.bc + 3'd1;
      unique case (idx)
         3'd0: nx.lead[23:16] = nx.lead[23:16] | item.stream_byte;
         3'd1: nx.lead[15:8]  = nx.lead[15:8]  | item.stream_byte;
         3'd2: nx.lead[7:0]   = nx.lead[7:0]   | item.stream_byte;
         default: begin
         end
      endcase

      if (idx == 3'd2) begin
         if (nx.lead != 24'd0 && nx.lead != 24'd1) begin
            // no start code: first two bytes are the header
            nx.hf = nx.lead[23:16];
            nx.hs = nx.lead[15:8];
            nx = check_header(nx);
            nx = take_payload(nx, item.stream_byte);
         end
      end else if (idx >= 3'd3) begin
         if (nx.lead == 24'd0 && idx == 3'd3) begin
            if (item.stream_byte != 8'h01) begin
               nx.bs.err = STATUS_HEADER;
               nx.pc = 2'd2;
            end
         end else begin
            prefix = (nx.lead == 24'd1) ? 3'd3 : ((nx.lead == 24'd0) ? 3'd4 : 3'd0);
            pos = idx - prefix;
            if (pos == 3'd0) begin
               nx.hf = item.stream_byte;
            end else if (pos == 3'd1) begin
               nx.hs = item.stream_byte;
               if (nx.bs.err == STATUS_OK) nx = check_header(nx);
            end else begin
               nx = take_payload(nx, item.stream_byte);
            end
         end
      end

      pending = (idx == 3'd2) && (nx.lead == 24'd0);
      priority if (pending) status = STATUS_HEADER;
      else if (nx.pc == '0) status = STATUS_SHORT;
      else if (nx.bs.err != STATUS_OK) status = nx.bs.err;
      else if (nx.bs.phase != PH_DONE) status = STATUS_NO_BITS;
      else status = STATUS_OK;

      result = '0;
      result.status = status;
      if (status == STATUS_OK) begin
         result.unit_kind            = nx.hf[6:1];
         result.temporal_level       = nx.hs[2:0];
         result.first_slice_flag     = nx.bs.flags[1];
         result.no_output_prior_flag = nx.bs.flags[0];
         result.pps_id               = nx.bs.sv;
      end

      // start over for the next unit
      st_in = item.last_byte ? ST_RESET : nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_RESET;
      end else if (step_en) begin
         st_ff <= st_in;
      end
   end

endmodule

/* rtl/hevc_slice_header_identity_parser_core.sv */
// Slice header identity parser, top level.
// Path: a byte accepted is held in in_item_ff and parsed when it advances; a result
// it completes is registered in rsp_item_ff and driven on rsp.
// Throughput: one byte per cycle; only a last byte waits, while a result is stalled.
// Reset: synchronous, active high; clears valid flags and all parse state.
// Depends on hsip_pkg and hsip_parser.
module hevc_slice_header_identity_parser_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hsip_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hsip_pkg::rsp_type rsp_data
);
   import hsip_pkg::*;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_item_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_item_ff;
   rsp_type result;
   logic    advance;

   // a byte that yields no result never waits on the result side
   assign advance   = in_valid_ff && (!in_item_ff.last_byte || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (advance && in_item_ff.last_byte) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   hsip_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_item_ff <= req_data;
      if (advance && in_item_ff.last_byte) rsp_item_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

endmodule

/* rtl/hsip_checker.sv */
// Port-level checks for the slice header identity parser.
// Depends on hsip_pkg; bound to hevc_slice_header_identity_parser_core below.
module hsip_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hsip_pkg::rsp_type rsp_data
);
   import hsip_pkg::*;

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |->
         rsp_data.unit_kind == '0 && rsp_data.temporal_level == '0 &&
         !rsp_data.first_slice_flag && !rsp_data.no_output_prior_flag &&
         rsp_data.pps_id == '0)
      else $error("error result carries nonzero fields");

   a_ok_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK |->
         rsp_data.temporal_level == 3'd1 && !rsp_data.unit_kind[5])
      else $error("ok result with unsupported header");

   a_noout_irap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_output_prior_flag |->
         rsp_data.unit_kind >= IRAP_FIRST_TYPE &&
         rsp_data.unit_kind <= IRAP_LAST_TYPE)
      else $error("no-output flag on non-IRAP type");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= STATUS_RANGE)
      else $error("undefined status code");

endmodule

bind hevc_slice_header_identity_parser_core hsip_checker u_hsip_checker (.*);
